// ===== hw/rtl/spl_pkg.sv =====
// Package for the speed PI loop: fixed-point constants, microcode control word and program.
package spl_pkg;

    localparam int SPEED_W   = 16;
    localparam int FRAC_W    = 16;
    localparam int ERR_W     = SPEED_W + 1;
    localparam int STATE_W   = 34;
    localparam int GAIN_W    = 24;
    localparam int LIMIT_W   = 15;
    localparam int DRIVE_W   = 16;
    localparam int CHUNK_W   = 17;
    localparam int MUL_A_W   = 25;
    localparam int MUL_B_W   = CHUNK_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 58;
    localparam int ALPHA_FRAC = 16;
    localparam int CFG_IDX_W = 2;
    localparam int PC_W      = 4;

    localparam logic [15:0] ALPHA_Q16       = 16'd19661;
    localparam logic [15:0] ONE_MINUS_ALPHA = 16'd45875;
    localparam logic [15:0] HALF_Q16        = 16'd32768;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd3000;
    localparam logic [ACC_W-1:0] DIV_BIAS = ACC_W'((64'd1 << (2 * FRAC_W)) - 64'd1);

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 2'd2;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [1:0] {MA_ALPHA, MA_OMA, MA_PGAIN, MA_IGAIN} mul_a_t;
    typedef enum logic [2:0] {MB_ERR, MB_F_LO, MB_F_HI, MB_I_LO, MB_I_HI} mul_b_t;
    typedef enum logic [2:0] {ACC_HOLD, ACC_ROUND, ACC_ADD, ACC_ADD_HI, ACC_CLEAR} acc_op_t;
    typedef enum logic [1:0] {SEQ_NEXT, SEQ_WAIT_IN, SEQ_WAIT_OUT, SEQ_JUMP} seq_cond_t;

    typedef struct packed {
        mul_a_t    mul_a;
        mul_b_t    mul_b;
        acc_op_t   acc_op;
        logic      ld_err;
        logic      wr_filt;
        logic      wr_integ;
        logic      wr_out;
        seq_cond_t cond;
        pc_t       target;
    } ctrl_t;

    function automatic ctrl_t cw(mul_a_t a, mul_b_t b, acc_op_t op, logic le, logic wf,
                                 logic wi, logic wo, seq_cond_t c, pc_t tgt);
        ctrl_t w;
        w.mul_a    = a;
        w.mul_b    = b;
        w.acc_op   = op;
        w.ld_err   = le;
        w.wr_filt  = wf;
        w.wr_integ = wi;
        w.wr_out   = wo;
        w.cond     = c;
        w.target   = tgt;
        return w;
    endfunction

    // The filter takes steps 0 to 3, the integral step 4, the drive sum steps 4 to 9.
    function automatic ctrl_t spl_rom(pc_t pc);
        ctrl_t w;
        unique case (pc)
            4'd0: w = cw(MA_OMA,   MB_F_LO, ACC_ROUND,  1'b1, 1'b0, 1'b0, 1'b0,
                         SEQ_WAIT_IN, 4'd0);
            4'd1: w = cw(MA_OMA,   MB_F_HI, ACC_ADD,    1'b0, 1'b0, 1'b0, 1'b0,
                         SEQ_NEXT, 4'd0);
            4'd2: w = cw(MA_ALPHA, MB_ERR,  ACC_ADD_HI, 1'b0, 1'b0, 1'b0, 1'b0,
                         SEQ_NEXT, 4'd0);
            4'd3: w = cw(MA_ALPHA, MB_ERR,  ACC_CLEAR,  1'b0, 1'b1, 1'b0, 1'b0,
                         SEQ_NEXT, 4'd0);
            4'd4: w = cw(MA_PGAIN, MB_F_LO, ACC_HOLD,   1'b0, 1'b0, 1'b1, 1'b0,
                         SEQ_NEXT, 4'd0);
            4'd5: w = cw(MA_PGAIN, MB_F_HI, ACC_ADD,    1'b0, 1'b0, 1'b0, 1'b0,
                         SEQ_NEXT, 4'd0);
            4'd6: w = cw(MA_IGAIN, MB_I_LO, ACC_ADD_HI, 1'b0, 1'b0, 1'b0, 1'b0,
                         SEQ_NEXT, 4'd0);
            4'd7: w = cw(MA_IGAIN, MB_I_HI, ACC_ADD,    1'b0, 1'b0, 1'b0, 1'b0,
                         SEQ_NEXT, 4'd0);
            4'd8: w = cw(MA_IGAIN, MB_I_HI, ACC_ADD_HI, 1'b0, 1'b0, 1'b0, 1'b0,
                         SEQ_NEXT, 4'd0);
            4'd9: w = cw(MA_IGAIN, MB_I_HI, ACC_HOLD,   1'b0, 1'b0, 1'b0, 1'b1,
                         SEQ_WAIT_OUT, 4'd0);
            default: w = cw(MA_ALPHA, MB_ERR, ACC_HOLD, 1'b0, 1'b0, 1'b0, 1'b0,
                            SEQ_JUMP, 4'd0);
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/spl_seq.sv =====
// Microcode sequencer: step counter, program ROM and jump conditions.
module spl_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              out_busy,
    output spl_pkg::ctrl_t    ctrl,
    output logic              in_ready
);

    spl_pkg::pc_t pc_reg;
    spl_pkg::pc_t pc_next;

    assign ctrl     = spl_pkg::spl_rom(pc_reg);
    assign in_ready = (ctrl.cond == spl_pkg::SEQ_WAIT_IN);

    always_comb begin
        pc_next = pc_reg;
        unique case (ctrl.cond)
            spl_pkg::SEQ_NEXT: begin
                pc_next = pc_reg + spl_pkg::PC_W'(1);
            end
            spl_pkg::SEQ_WAIT_IN: begin
                if (in_valid) begin
                    pc_next = pc_reg + spl_pkg::PC_W'(1);
                end
            end
            spl_pkg::SEQ_WAIT_OUT: begin
                if (!out_busy) begin
                    pc_next = ctrl.target;
                end
            end
            spl_pkg::SEQ_JUMP: begin
                pc_next = ctrl.target;
            end
            default: begin
                pc_next = ctrl.target;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hw/rtl/speed_pi_loop_with_lowpass.sv =====
// Top level of the speed PI loop with low-pass filtered error and clamped integral.
// Each input beat carries a measured and a target speed; the block filters their
// difference (alpha 0.3 in Q0.16), adds it to an integral clamped to plus or minus
// integ_limit, and returns one drive beat of prop_gain times filtered error plus
// integ_gain times integral, truncated toward zero and saturated to 16 bits signed.
// Each item runs through a ten-step microprogram that passes all products through
// one shared 25 by 18 bit multiplier. An input beat is accepted only at the first
// step, and the drive beat is registered at the last; the next input beat is accepted
// only after that. The last step holds only while the previous drive beat is untaken,
// and no new input beat is accepted during that hold.
// Gains are signed Q8.16 and may be written only while the block is idle.
module speed_pi_loop_with_lowpass (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [15:0] measured_speed, [31:16] target_speed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] drive
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    localparam int SUM_W = spl_pkg::STATE_W + 1;
    localparam int Q_W   = spl_pkg::ACC_W - 2 * spl_pkg::FRAC_W;

    spl_pkg::ctrl_t ctrl;
    logic           out_busy;
    logic           out_load;

    logic signed [spl_pkg::GAIN_W-1:0]  prop_gain_reg;
    logic signed [spl_pkg::GAIN_W-1:0]  integ_gain_reg;
    logic        [spl_pkg::LIMIT_W-1:0] integ_limit_reg;

    logic signed [spl_pkg::ERR_W-1:0]   err_reg;
    logic signed [spl_pkg::STATE_W-1:0] filt_reg;
    logic signed [spl_pkg::STATE_W-1:0] integ_reg;
    logic signed [spl_pkg::PROD_W-1:0]  prod_reg;
    logic signed [spl_pkg::PROD_W-1:0]  prod_next;
    logic signed [spl_pkg::ACC_W-1:0]   acc_reg;
    logic signed [spl_pkg::ACC_W-1:0]   acc_next;
    logic signed [spl_pkg::STATE_W-1:0] filt_next;
    logic signed [spl_pkg::STATE_W-1:0] integ_next;
    logic signed [spl_pkg::DRIVE_W-1:0] drive_reg;
    logic signed [spl_pkg::DRIVE_W-1:0] drive_next;
    logic                               m_tvalid_reg;

    logic signed [spl_pkg::MUL_A_W-1:0] mul_a;
    logic signed [spl_pkg::MUL_B_W-1:0] mul_b;
    logic signed [spl_pkg::ERR_W-1:0]   err_in;
    logic signed [SUM_W-1:0]            integ_sum;
    logic signed [SUM_W-1:0]            lim_pos;
    logic signed [SUM_W-1:0]            lim_neg;
    logic signed [spl_pkg::ACC_W-1:0]   acc_adj;
    logic signed [Q_W-1:0]              quot;

    spl_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_busy (out_busy),
        .ctrl     (ctrl),
        .in_ready (s_tready)
    );

    assign out_busy = m_tvalid_reg && !m_tready;
    assign out_load = ctrl.wr_out && !out_busy;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = drive_reg;

    assign err_in = spl_pkg::ERR_W'($signed(s_tdata[15:0]))
                  - spl_pkg::ERR_W'($signed(s_tdata[31:16]));

    always_comb begin
        unique case (ctrl.mul_a)
            spl_pkg::MA_ALPHA: mul_a = $signed({9'd0, spl_pkg::ALPHA_Q16});
            spl_pkg::MA_OMA:   mul_a = $signed({9'd0, spl_pkg::ONE_MINUS_ALPHA});
            spl_pkg::MA_PGAIN: mul_a = spl_pkg::MUL_A_W'(prop_gain_reg);
            spl_pkg::MA_IGAIN: mul_a = spl_pkg::MUL_A_W'(integ_gain_reg);
            default:           mul_a = '0;
        endcase
    end

    always_comb begin
        unique case (ctrl.mul_b)
            spl_pkg::MB_ERR:  mul_b = spl_pkg::MUL_B_W'(err_reg);
            spl_pkg::MB_F_LO: mul_b = $signed({1'b0, filt_reg[spl_pkg::CHUNK_W-1:0]});
            spl_pkg::MB_F_HI: mul_b = spl_pkg::MUL_B_W'(
                                  $signed(filt_reg[spl_pkg::STATE_W-1:spl_pkg::CHUNK_W]));
            spl_pkg::MB_I_LO: mul_b = $signed({1'b0, integ_reg[spl_pkg::CHUNK_W-1:0]});
            spl_pkg::MB_I_HI: mul_b = spl_pkg::MUL_B_W'(
                                  $signed(integ_reg[spl_pkg::STATE_W-1:spl_pkg::CHUNK_W]));
            default:          mul_b = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb begin
        unique case (ctrl.acc_op)
            spl_pkg::ACC_HOLD:   acc_next = acc_reg;
            spl_pkg::ACC_ROUND:  acc_next = $signed({{(spl_pkg::ACC_W - 16){1'b0}},
                                                     spl_pkg::HALF_Q16});
            spl_pkg::ACC_ADD:    acc_next = acc_reg + spl_pkg::ACC_W'(prod_reg);
            spl_pkg::ACC_ADD_HI: acc_next = acc_reg
                                          + (spl_pkg::ACC_W'(prod_reg) <<< spl_pkg::CHUNK_W);
            spl_pkg::ACC_CLEAR:  acc_next = '0;
            default:             acc_next = acc_reg;
        endcase
    end

    assign filt_next = spl_pkg::STATE_W'((acc_reg >>> spl_pkg::ALPHA_FRAC)
                                         + spl_pkg::ACC_W'(prod_reg));

    assign integ_sum = SUM_W'(integ_reg) + SUM_W'(filt_reg);
    assign lim_pos   = $signed({{(SUM_W - spl_pkg::LIMIT_W - spl_pkg::FRAC_W){1'b0}},
                                integ_limit_reg, {spl_pkg::FRAC_W{1'b0}}});
    assign lim_neg   = -lim_pos;

    always_comb begin
        priority if (integ_sum > lim_pos) begin
            integ_next = spl_pkg::STATE_W'(lim_pos);
        end else if (integ_sum < lim_neg) begin
            integ_next = spl_pkg::STATE_W'(lim_neg);
        end else begin
            integ_next = spl_pkg::STATE_W'(integ_sum);
        end
    end

    assign acc_adj = acc_reg[spl_pkg::ACC_W-1] ? acc_reg + $signed(spl_pkg::DIV_BIAS)
                                               : acc_reg;
    assign quot    = $signed(acc_adj[spl_pkg::ACC_W-1:2*spl_pkg::FRAC_W]);

    always_comb begin
        priority if (quot > Q_W'(32767)) begin
            drive_next = 16'sh7FFF;
        end else if (quot < -Q_W'(32768)) begin
            drive_next = -16'sh8000;
        end else begin
            drive_next = spl_pkg::DRIVE_W'(quot);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            integ_limit_reg <= spl_pkg::LIMIT_RESET;
            filt_reg        <= '0;
            integ_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    spl_pkg::REG_PROP_GAIN:   prop_gain_reg   <= $signed(cfg_wdata);
                    spl_pkg::REG_INTEG_GAIN:  integ_gain_reg  <= $signed(cfg_wdata);
                    spl_pkg::REG_INTEG_LIMIT: integ_limit_reg <= cfg_wdata[spl_pkg::LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (ctrl.wr_filt) begin
                filt_reg <= filt_next;
            end
            if (ctrl.wr_integ) begin
                integ_reg <= integ_next;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        if (ctrl.ld_err && s_tvalid) begin
            err_reg <= err_in;
        end
        if (out_load) begin
            drive_reg <= drive_next;
        end
    end

endmodule
